// File: rtl/tpc_pkg.sv
// Package for the trie prefix counter: item types, kind and status codes,
// default sizes and the symbol decoder. Depends on nothing.
`default_nettype none

package tpc_pkg;

    localparam int DEF_NODE_CAPACITY = 65536;
    localparam int DEF_COUNT_BITS    = 32;
    localparam int ALPHABET_SIZE     = 62;
    localparam int UPPER_BASE        = 26;
    localparam int DIGIT_BASE        = 52;
    localparam int PREFIX_W          = 32;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] symbol;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [PREFIX_W-1:0] prefix_count;
        logic [1:0]          status;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res_push;

    // Returns {valid, code}; the code is 0..61 for letters and digits.
    function automatic logic [6:0] symbol_code(input logic [7:0] sym);
        logic [6:0] res;
        res = '0;
        if (sym >= "a" && sym <= "z") begin
            res = {1'b1, 6'(sym - "a")};
        end else if (sym >= "A" && sym <= "Z") begin
            res = {1'b1, 6'(sym - "A") + 6'(UPPER_BASE)};
        end else if (sym >= "0" && sym <= "9") begin
            res = {1'b1, 6'(sym - "0") + 6'(DIGIT_BASE)};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tpc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Depends on nothing.
`default_nettype none

module tpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/tpc_out_reg.sv
// Output register of the trie prefix counter: holds one result item while
// the receiver stalls. Depends on tpc_pkg.
`default_nettype none

module tpc_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tpc_pkg::t_res_push i_res,
    output logic                    o_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tpc_pkg::t_out_item      o_out_item
);

    import tpc_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    assign o_ready = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_res.valid) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_res.valid) begin
            r_item <= i_res.item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

`default_nettype wire

// File: rtl/tpc_walker.sv
// Sequencer of the trie prefix counter: walks the child table and node
// records held in two RAMs, allocates nodes and forms results. Depends on tpc_pkg.
`default_nettype none

module tpc_walker #(
    parameter int NODE_CAPACITY = 65536,
    parameter int COUNT_BITS    = 32
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_stall,
    input  wire tpc_pkg::t_in_item                       i_in_item,
    output logic                                         o_ct_we,
    output logic [$clog2(NODE_CAPACITY*tpc_pkg::ALPHABET_SIZE)-1:0] o_ct_waddr,
    output logic [$clog2(NODE_CAPACITY)-1:0]             o_ct_wdata,
    output logic [$clog2(NODE_CAPACITY*tpc_pkg::ALPHABET_SIZE)-1:0] o_ct_raddr,
    input  wire logic [$clog2(NODE_CAPACITY)-1:0]        i_ct_rdata,
    output logic                                         o_nm_we,
    output logic [$clog2(NODE_CAPACITY)-1:0]             o_nm_waddr,
    output logic [$clog2(NODE_CAPACITY*tpc_pkg::ALPHABET_SIZE)+COUNT_BITS-1:0] o_nm_wdata,
    output logic [$clog2(NODE_CAPACITY)-1:0]             o_nm_raddr,
    input  wire logic [$clog2(NODE_CAPACITY*tpc_pkg::ALPHABET_SIZE)+COUNT_BITS-1:0] i_nm_rdata,
    output tpc_pkg::t_res_push                           o_res,
    input  wire logic                                    i_res_ready
);

    import tpc_pkg::*;

    localparam int ID_W   = $clog2(NODE_CAPACITY);
    localparam int USED_W = $clog2(NODE_CAPACITY + 1);
    localparam int SLOT_W = $clog2(NODE_CAPACITY * ALPHABET_SIZE);
    localparam int NM_W   = SLOT_W + COUNT_BITS;
    localparam logic [USED_W-1:0] CAPACITY_V = USED_W'(NODE_CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_NODE = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]            r_state,    n_state;
    logic [USED_W-1:0]     r_used,     n_used;
    logic [ID_W-1:0]       r_cur,      n_cur;
    logic [SLOT_W-1:0]     r_cur_par,  n_cur_par;
    logic [COUNT_BITS-1:0] r_cur_cnt,  n_cur_cnt;
    logic [COUNT_BITS-1:0] r_root_cnt, n_root_cnt;
    logic                  r_miss,     n_miss;
    logic [1:0]            r_err,      n_err;
    logic [SLOT_W-1:0]     r_slot,     n_slot;
    logic                  r_kind_ins, n_kind_ins;
    logic                  r_last,     n_last;
    logic [ID_W-1:0]       r_child,    n_child;
    logic                  r_cand,     n_cand;
    t_out_item             r_pend,     n_pend;

    logic                  w_in_fire;
    logic [6:0]            w_sym;
    logic [ID_W+5:0]       w_slot_full;
    logic [SLOT_W-1:0]     w_slot;
    logic [COUNT_BITS-1:0] w_cur_cnt;
    logic [COUNT_BITS-1:0] w_bump;
    logic [SLOT_W-1:0]     w_nm_par;
    logic [COUNT_BITS-1:0] w_nm_cnt;
    logic [COUNT_BITS-1:0] w_nm_bump;
    logic                  w_hit;
    logic [COUNT_BITS-1:0] w_ans;
    logic [PREFIX_W-1:0]   w_ans_out;
    logic                  w_emit;
    t_out_item             w_emit_item;
    logic [1:0]            w_err_now;

    assign w_in_fire   = (r_state == S_IDLE) && i_in_valid;
    assign w_sym       = symbol_code(i_in_item.symbol);
    assign w_slot_full = (ID_W+6)'(r_cur) * (ID_W+6)'(ALPHABET_SIZE) + (ID_W+6)'(w_sym[5:0]);
    assign w_slot      = w_slot_full[SLOT_W-1:0];
    assign w_cur_cnt   = (r_cur == '0) ? r_root_cnt : r_cur_cnt;
    assign w_bump      = (w_cur_cnt == '1) ? w_cur_cnt : w_cur_cnt + COUNT_BITS'(1);
    assign w_nm_par    = i_nm_rdata[NM_W-1:COUNT_BITS];
    assign w_nm_cnt    = i_nm_rdata[COUNT_BITS-1:0];
    assign w_nm_bump   = (w_nm_cnt == '1) ? w_nm_cnt : w_nm_cnt + COUNT_BITS'(1);
    assign w_hit       = r_cand && (w_nm_par == r_slot);
    assign w_ans       = (r_state == S_NODE && w_hit && !r_kind_ins) ? w_nm_cnt : '0;

    generate
        if (COUNT_BITS > PREFIX_W) begin : g_sat
            assign w_ans_out = (|w_ans[COUNT_BITS-1:PREFIX_W]) ? '1 : w_ans[PREFIX_W-1:0];
        end else begin : g_ext
            assign w_ans_out = PREFIX_W'(w_ans);
        end
    endgenerate

    assign o_in_stall = (r_state != S_IDLE);
    assign o_ct_raddr = w_slot;
    assign o_nm_raddr = i_ct_rdata;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_cur       = r_cur;
        n_cur_par   = r_cur_par;
        n_cur_cnt   = r_cur_cnt;
        n_root_cnt  = r_root_cnt;
        n_miss      = r_miss;
        n_err       = r_err;
        n_slot      = r_slot;
        n_kind_ins  = r_kind_ins;
        n_last      = r_last;
        n_child     = r_child;
        n_cand      = r_cand;
        n_pend      = r_pend;
        o_ct_we     = 1'b0;
        o_ct_waddr  = r_slot;
        o_ct_wdata  = r_used[ID_W-1:0];
        o_nm_we     = 1'b0;
        o_nm_waddr  = r_cur;
        o_nm_wdata  = {r_cur_par, w_bump};
        o_res       = '0;
        w_emit      = 1'b0;
        w_emit_item = '0;
        w_err_now   = r_err;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    unique case (i_in_item.kind)
                        KIND_CLEAR: begin
                            n_used      = USED_W'(1);
                            n_root_cnt  = '0;
                            n_cur       = '0;
                            n_miss      = 1'b0;
                            n_err       = STATUS_OK;
                            w_emit      = 1'b1;
                            w_emit_item = '0;
                        end
                        KIND_INSERT, KIND_QUERY: begin
                            if (r_miss || !w_sym[6]) begin
                                if (!r_miss) begin
                                    n_miss = 1'b1;
                                    if (r_err == STATUS_OK) begin
                                        w_err_now = STATUS_BAD;
                                    end
                                    n_err = w_err_now;
                                end
                                if (i_in_item.last_char) begin
                                    w_emit             = 1'b1;
                                    w_emit_item.status = w_err_now;
                                    n_cur              = '0;
                                    n_miss             = 1'b0;
                                    n_err              = STATUS_OK;
                                end
                            end else begin
                                n_slot     = w_slot;
                                n_kind_ins = (i_in_item.kind == KIND_INSERT);
                                n_last     = i_in_item.last_char;
                                n_state    = S_LOOK;
                                if (i_in_item.kind == KIND_INSERT) begin
                                    n_cur_cnt = w_bump;
                                    if (r_cur == '0) begin
                                        n_root_cnt = w_bump;
                                    end else begin
                                        o_nm_we = 1'b1;
                                    end
                                end
                            end
                        end
                        KIND_NONE: begin
                        end
                    endcase
                end
            end
            S_LOOK: begin
                n_child = i_ct_rdata;
                n_cand  = 1'b0;
                if ((i_ct_rdata != '0) && (USED_W'(i_ct_rdata) < r_used)) begin
                    n_cand = 1'b1;
                end
                n_state = S_NODE;
            end
            S_NODE: begin
                n_state = S_IDLE;
                if (w_hit) begin
                    n_cur     = r_child;
                    n_cur_par = r_slot;
                    n_cur_cnt = w_nm_cnt;
                    if (r_kind_ins && r_last) begin
                        o_nm_we    = 1'b1;
                        o_nm_waddr = r_child;
                        o_nm_wdata = {r_slot, w_nm_bump};
                        n_cur_cnt  = w_nm_bump;
                    end
                end else if (!r_kind_ins) begin
                    n_miss = 1'b1;
                end else if (r_used < CAPACITY_V) begin
                    o_ct_we    = 1'b1;
                    o_nm_we    = 1'b1;
                    o_nm_waddr = r_used[ID_W-1:0];
                    o_nm_wdata = {r_slot, r_last ? COUNT_BITS'(1) : COUNT_BITS'(0)};
                    n_used     = r_used + USED_W'(1);
                    n_cur      = r_used[ID_W-1:0];
                    n_cur_par  = r_slot;
                    n_cur_cnt  = r_last ? COUNT_BITS'(1) : COUNT_BITS'(0);
                end else begin
                    n_miss = 1'b1;
                    if (r_err == STATUS_OK) begin
                        w_err_now = STATUS_FULL;
                    end
                    n_err = w_err_now;
                end
                if (r_last) begin
                    w_emit                   = 1'b1;
                    w_emit_item.prefix_count = w_ans_out;
                    w_emit_item.status       = w_err_now;
                    n_cur                    = '0;
                    n_miss                   = 1'b0;
                    n_err                    = STATUS_OK;
                end
            end
            S_HOLD: begin
                if (i_res_ready) begin
                    o_res.valid = 1'b1;
                    o_res.item  = r_pend;
                    n_state     = S_IDLE;
                end
            end
        endcase

        if (w_emit) begin
            if (i_res_ready) begin
                o_res.valid = 1'b1;
                o_res.item  = w_emit_item;
            end else begin
                n_state = S_HOLD;
                n_pend  = w_emit_item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= USED_W'(1);
            r_cur      <= '0;
            r_root_cnt <= '0;
            r_miss     <= 1'b0;
            r_err      <= STATUS_OK;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_cur      <= n_cur;
            r_root_cnt <= n_root_cnt;
            r_miss     <= n_miss;
            r_err      <= n_err;
        end
        r_cur_par  <= n_cur_par;
        r_cur_cnt  <= n_cur_cnt;
        r_slot     <= n_slot;
        r_kind_ins <= n_kind_ins;
        r_last     <= n_last;
        r_child    <= n_child;
        r_cand     <= n_cand;
        r_pend     <= n_pend;
    end

`ifndef SYNTHESIS
    a_cur_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        USED_W'(r_cur) < r_used)
        else $error("Cursor points at a node that is not allocated.");

    a_alloc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ct_we |-> r_used < CAPACITY_V)
        else $error("Child link written with the node store full.");

    a_root_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nm_we |-> o_nm_waddr != '0)
        else $error("Root node record written to the node RAM.");

    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in_item.kind == KIND_CLEAR) |=> (r_used == USED_W'(1) && r_cur == '0))
        else $error("Clear did not restore allocation and cursor.");

    a_push_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> i_res_ready)
        else $error("Result pushed into a full output register.");
`endif

endmodule

`default_nettype wire

// File: rtl/trie_prefix_counter.sv
// Top level of the trie prefix counter: sequencer, child table RAM, node
// record RAM and output register. Depends on tpc_pkg, tpc_ram, tpc_walker, tpc_out_reg.
//
// Items enter on the input channel one character at a time; each word ends
// with an item whose last_char is set. A result item leaves on the output
// channel for every word end and every clear, and none for other items.
// A clear, an unused kind, or a character after a bad symbol or miss is
// handled in the idle state alone. A character that walks the trie passes
// through the child table read, then the read of the child's node record,
// then the update. These two dependent RAM reads set the rate. A result goes
// to the output register, or first waits inside the block while that register is full.
// Reset leaves both RAMs as they are. A child link counts only if it points
// below the allocation count and the child's record names that link as its
// parent, so reset and clear need no clearing pass.
// While the receiver stalls, one result waits in the output register and
// the block keeps taking items; a second result waits inside the block,
// which then stalls its input until the output register frees.
`default_nettype none

module trie_prefix_counter #(
    parameter int NODE_CAPACITY = tpc_pkg::DEF_NODE_CAPACITY,
    parameter int COUNT_BITS    = tpc_pkg::DEF_COUNT_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire tpc_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output tpc_pkg::t_out_item     o_out_item
);

    import tpc_pkg::*;

    localparam int ID_W     = $clog2(NODE_CAPACITY);
    localparam int CT_DEPTH = NODE_CAPACITY * ALPHABET_SIZE;
    localparam int SLOT_W   = $clog2(CT_DEPTH);
    localparam int NM_W     = SLOT_W + COUNT_BITS;

    logic              ct_we;
    logic [SLOT_W-1:0] ct_waddr;
    logic [ID_W-1:0]   ct_wdata;
    logic [SLOT_W-1:0] ct_raddr;
    logic [ID_W-1:0]   ct_rdata;
    logic              nm_we;
    logic [ID_W-1:0]   nm_waddr;
    logic [NM_W-1:0]   nm_wdata;
    logic [ID_W-1:0]   nm_raddr;
    logic [NM_W-1:0]   nm_rdata;
    t_res_push         res;
    logic              res_ready;

    tpc_walker #(
        .NODE_CAPACITY (NODE_CAPACITY),
        .COUNT_BITS    (COUNT_BITS)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_ct_we     (ct_we),
        .o_ct_waddr  (ct_waddr),
        .o_ct_wdata  (ct_wdata),
        .o_ct_raddr  (ct_raddr),
        .i_ct_rdata  (ct_rdata),
        .o_nm_we     (nm_we),
        .o_nm_waddr  (nm_waddr),
        .o_nm_wdata  (nm_wdata),
        .o_nm_raddr  (nm_raddr),
        .i_nm_rdata  (nm_rdata),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    tpc_ram #(
        .WIDTH (ID_W),
        .DEPTH (CT_DEPTH)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (ct_we),
        .i_waddr (ct_waddr),
        .i_wdata (ct_wdata),
        .i_raddr (ct_raddr),
        .o_rdata (ct_rdata)
    );

    tpc_ram #(
        .WIDTH (NM_W),
        .DEPTH (NODE_CAPACITY)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (nm_we),
        .i_waddr (nm_waddr),
        .i_wdata (nm_wdata),
        .i_raddr (nm_raddr),
        .o_rdata (nm_rdata)
    );

    tpc_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .o_ready     (res_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// File: verif/tb_trie_prefix_counter.sv
// Self-checking testbench for trie_prefix_counter: directed and random words,
// predicted answers compared with every result item. Depends on tpc_pkg and
// the RTL of the block, built with a small node store and narrow counts.
`default_nettype none

module tb_trie_prefix_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import tpc_pkg::*;

    localparam int NODE_CAP    = 32;
    localparam int CNT_BITS    = 8;
    localparam int CNT_MAX     = (1 << CNT_BITS) - 1;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 20;

    typedef struct {
        t_in_item item;
        bit       drain;
    } t_queued_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_item;

    t_queued_char char_q[$];
    t_out_item    answer_q[$];
    int           sent       = 0;
    int           calm_from  = 0;
    int           gap_left   = 0;
    int           stall_left = 0;
    int           errors     = 0;
    int           cycles     = 0;
    bit           took_in    = 1'b0;

    int unsigned  links  [NODE_CAP*ALPHABET_SIZE];
    int unsigned  visits [NODE_CAP];
    int unsigned  nodes_alloc = 1;
    int unsigned  walk_node   = 0;
    bit           walk_dead   = 1'b0;
    logic [1:0]   walk_err    = STATUS_OK;

    trie_prefix_counter #(
        .NODE_CAPACITY(NODE_CAP),
        .COUNT_BITS   (CNT_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic void bump_visits(input int unsigned node);
        if (visits[node] < CNT_MAX) begin
            visits[node] = visits[node] + 1;
        end
    endfunction

    function automatic void mark_fault(input logic [1:0] code);
        walk_dead = 1'b1;
        if (walk_err == STATUS_OK) begin
            walk_err = code;
        end
    endfunction

    function automatic void walk_trie(input t_in_item it);
        int          code;
        int unsigned slot;
        int unsigned nxt;
        t_out_item   ans;
        ans = '0;
        if (it.kind == KIND_NONE) begin
            return;
        end
        if (it.kind == KIND_CLEAR) begin
            links       = '{default: 0};
            visits      = '{default: 0};
            nodes_alloc = 1;
            walk_node   = 0;
            walk_dead   = 1'b0;
            walk_err    = STATUS_OK;
            answer_q.push_back(ans);
            return;
        end
        if (!walk_dead) begin
            code = -1;
            if (it.symbol >= "a" && it.symbol <= "z") begin
                code = int'(it.symbol - "a");
            end else if (it.symbol >= "A" && it.symbol <= "Z") begin
                code = int'(it.symbol - "A") + UPPER_BASE;
            end else if (it.symbol >= "0" && it.symbol <= "9") begin
                code = int'(it.symbol - "0") + DIGIT_BASE;
            end
            if (code < 0) begin
                mark_fault(STATUS_BAD);
            end else begin
                slot = walk_node * ALPHABET_SIZE + code;
                nxt  = links[slot];
                if (it.kind == KIND_INSERT) begin
                    bump_visits(walk_node);
                    if (nxt == 0) begin
                        if (nodes_alloc < NODE_CAP) begin
                            nxt         = nodes_alloc;
                            nodes_alloc = nodes_alloc + 1;
                            links[slot] = nxt;
                        end else begin
                            mark_fault(STATUS_FULL);
                        end
                    end
                    if (nxt != 0) begin
                        walk_node = nxt;
                        if (it.last_char) begin
                            bump_visits(nxt);
                        end
                    end
                end else if (nxt == 0) begin
                    walk_dead = 1'b1;
                end else begin
                    walk_node = nxt;
                end
            end
        end
        if (!it.last_char) begin
            return;
        end
        if (it.kind == KIND_QUERY && !walk_dead) begin
            ans.prefix_count = PREFIX_W'(visits[walk_node]);
        end
        ans.status = walk_err;
        answer_q.push_back(ans);
        walk_node = 0;
        walk_dead = 1'b0;
        walk_err  = STATUS_OK;
    endfunction

    task automatic add_char(input logic [1:0] k, input logic [7:0] s, input logic l,
                            input bit drain = 1'b0);
        t_queued_char qc;
        qc.item.kind      = k;
        qc.item.symbol    = s;
        qc.item.last_char = l;
        qc.drain          = drain;
        char_q.push_back(qc);
    endtask

    task automatic add_word(input logic [1:0] k, input string w);
        for (int i = 0; i < w.len(); i++) begin
            add_char(k, w[i], i == w.len() - 1);
        end
    endtask

    function automatic logic [7:0] pick_symbol();
        string hot;
        int    r;
        int    c;
        hot = "abcZ09";
        r   = $urandom_range(0, 99);
        c   = $urandom_range(0, ALPHABET_SIZE - 1);
        if (r < 80) begin
            return hot[$urandom_range(0, hot.len() - 1)];
        end else if (r < 92) begin
            if (c < UPPER_BASE) begin
                return 8'("a" + c);
            end else if (c < DIGIT_BASE) begin
                return 8'("A" + c - UPPER_BASE);
            end
            return 8'("0" + c - DIGIT_BASE);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_random_word();
        int         n;
        int         mode;
        logic [1:0] k;
        n    = $urandom_range(1, 4);
        mode = $urandom_range(0, 99);
        if (mode < 3) begin
            add_char(KIND_CLEAR, 8'($urandom), 1'($urandom));
            return;
        end
        if (mode < 5) begin
            add_char(KIND_NONE, 8'($urandom), 1'($urandom));
            return;
        end
        k = (mode < 55) ? KIND_INSERT : KIND_QUERY;
        for (int i = 0; i < n; i++) begin
            if (mode >= 92) begin
                k = $urandom_range(0, 1) ? KIND_INSERT : KIND_QUERY;
            end
            if (i < n - 1 && $urandom_range(0, 99) < 2) begin
                add_char(KIND_CLEAR, 8'($urandom), 1'($urandom));
            end
            add_char(k, pick_symbol(), i == n - 1);
        end
    endtask

    always @(negedge i_clk) begin
        logic     nv;
        t_in_item ni;
        logic     ns;
        bit       calm;
        nv   = 1'b0;
        ni   = i_in_item;
        ns   = 1'b0;
        calm = (sent >= calm_from) || ((sent / 50) % 4 == 3);
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (i_in_valid && !took_in) begin
            nv = 1'b1;
        end else begin
            if (i_in_valid) begin
                sent = sent + 1;
            end
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
            end else if (sent < char_q.size()) begin
                if (!(char_q[sent].drain && answer_q.size() != 0)) begin
                    if (!calm && $urandom_range(0, 99) < 20) begin
                        gap_left = $urandom_range(0, 4);
                    end else begin
                        nv = 1'b1;
                        ni = char_q[sent].item;
                    end
                end
            end
        end
        if (stall_left > 0 && !calm) begin
            ns         = 1'b1;
            stall_left = stall_left - 1;
        end else if (i_rst_n && !calm && $urandom_range(0, 99) < 20) begin
            ns         = 1'b1;
            stall_left = $urandom_range(0, 4);
        end else begin
            stall_left = 0;
        end
        i_in_valid  <= nv;
        i_in_item   <= ni;
        i_out_stall <= ns;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            took_in <= 1'b0;
        end else begin
            took_in <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                walk_trie(i_in_item);
            end
            if (o_out_valid && !i_out_stall) begin
                if (answer_q.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: unexpected item, expected none, got count %0d status %0d",
                             $time, o_out_item.prefix_count, o_out_item.status);
                end else begin
                    want = answer_q.pop_front();
                    if (o_out_item.prefix_count !== want.prefix_count) begin
                        errors = errors + 1;
                        $display("%0t: prefix_count expected %0d, got %0d",
                                 $time, want.prefix_count, o_out_item.prefix_count);
                    end
                    if (o_out_item.status !== want.status) begin
                        errors = errors + 1;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, o_out_item.status);
                    end
                end
            end
        end
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int r;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;

        add_word(KIND_QUERY, "a");
        add_word(KIND_INSERT, "ab");
        add_word(KIND_INSERT, "a");
        add_word(KIND_QUERY, "ab");
        add_word(KIND_QUERY, "a");
        add_word(KIND_INSERT, "zA0");
        add_word(KIND_INSERT, "Z9");
        add_word(KIND_QUERY, "zA");
        add_char(KIND_INSERT, "a", 1'b0);
        add_char(KIND_INSERT, 8'hFF, 1'b0);
        add_char(KIND_INSERT, "b", 1'b1);
        add_char(KIND_QUERY, 8'h00, 1'b1);
        add_char(KIND_NONE, "a", 1'b1);
        add_char(KIND_INSERT, "a", 1'b0);
        add_char(KIND_QUERY, "b", 1'b1);
        add_char(KIND_INSERT, "x", 1'b0);
        add_char(KIND_CLEAR, 8'h00, 1'b0);
        add_word(KIND_QUERY, "a");

        while (char_q.size() < 300) begin
            add_random_word();
        end

        // Long run on one prefix so that its count reaches saturation.
        add_char(KIND_CLEAR, 8'hFF, 1'b1, 1'b1);
        for (int i = 0; i < 300; i++) begin
            r = $urandom_range(0, 99);
            if (r < 88) begin
                add_word(KIND_INSERT, "a");
            end else if (r < 94) begin
                add_word(KIND_QUERY, "a");
            end else begin
                add_random_word();
            end
        end
        add_word(KIND_QUERY, "a");

        calm_from = char_q.size();
        while (char_q.size() < calm_from + 70) begin
            add_random_word();
        end
        char_q[calm_from].drain = 1'b1;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (sent < char_q.size() || answer_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
